FILE: sv/b2b_pkg.sv
// package for the blake2b hash engine: types, constants, helper functions
`default_nettype none
package b2b_pkg;

   localparam int WordW = 64;
   localparam int BlockWords = 16;
   localparam int ChainWords = 8;
   localparam int Rounds = 12;
   localparam int QueueDepth = 4;

   // configuration register indexes
   localparam logic [1:0] CSR_DIGEST_LENGTH = 2'd0;
   localparam logic [1:0] CSR_KEY_LENGTH = 2'd1;
   localparam logic [1:0] CSR_LAST_NODE = 2'd2;

   // item kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef logic [WordW-1:0] word_type;

   typedef struct packed {
      logic       kind;
      word_type   data_word;
      logic [3:0] byte_count;
   } req_type;

   typedef struct packed {
      word_type   digest_word;
      logic [2:0] word_index;
      logic       last_word;
   } rsp_type;

   typedef struct packed {
      logic [6:0] digest_length;
      logic [6:0] key_length;
      logic       last_node;
   } csr_type;

   // work unit handed from front to back
   typedef struct packed {
      logic       finish;
      word_type   data_word;
      logic [3:0] byte_count;
   } cmd_type;

   function automatic word_type iv_word(input logic [2:0] i);
      word_type r;
      case (i)
         3'd0: r = 64'h6A09E667F3BCC908;
         3'd1: r = 64'hBB67AE8584CAA73B;
         3'd2: r = 64'h3C6EF372FE94F82B;
         3'd3: r = 64'hA54FF53A5F1D36F1;
         3'd4: r = 64'h510E527FADE682D1;
         3'd5: r = 64'h9B05688C2B3E6C1F;
         3'd6: r = 64'h1F83D9ABFB41BD6B;
         default: r = 64'h5BE0CD19137E2179;
      endcase
      return r;
   endfunction

   // message schedule: index of word j in round r
   function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] j);
      logic [63:0] row;
      case (r)
         4'd0, 4'd10: row = 64'hFEDCBA9876543210;
         4'd1, 4'd11: row = 64'h357B20C16DF984AE;
         4'd2: row = 64'h491763EADF250C8B;
         4'd3: row = 64'h8F04A562EBCD1397;
         4'd4: row = 64'hD386CB1EFA427509;
         4'd5: row = 64'h91EF57D438B0A6C2;
         4'd6: row = 64'hB8293670A4DEF15C;
         4'd7: row = 64'hA2684F05931CE7BD;
         4'd8: row = 64'h5A417D2C803B9EF6;
         default: row = 64'h0DC3E9BF5167482A;
      endcase
      return row[j*4 +: 4];
   endfunction

   function automatic logic [6:0] eff_dl(input logic [6:0] dl);
      logic [6:0] r;
      if (dl == 7'd0) r = 7'd1;
      else if (dl > 7'd64) r = 7'd64;
      else r = dl;
      return r;
   endfunction

   function automatic word_type param_word(input csr_type c);
      logic [6:0] kl;
      kl = (c.key_length > 7'd64) ? 7'd64 : c.key_length;
      return {32'd0, 8'd1, 8'd1, 1'b0, kl, 1'b0, eff_dl(c.digest_length)};
   endfunction

endpackage
`default_nettype wire

FILE: sv/b2b_if.sv
// valid/ready channel interfaces for the hash engine
`default_nettype none
interface b2b_req_if;
   logic              valid;
   logic              ready;
   b2b_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface b2b_rsp_if;
   logic              valid;
   logic              ready;
   b2b_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface b2b_csr_if;
   logic              valid;
   logic              ready;
   logic [1:0]        index;
   b2b_pkg::word_type data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/b2b_front.sv
// front part: accepts items, drops empty data items, queues work for the back
`default_nettype none
module b2b_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            flush,
   b2b_req_if.sink              req,
   output b2b_pkg::cmd_type     cmd,
   output logic                 cmd_valid,
   input  wire logic            cmd_take
);
   import b2b_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   cmd_type          q_mem [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]    cnt_ff;
   logic             push;
   cmd_type          cls;

   // classify: clamp byte count, mark finish
   always_comb begin
      cls.finish = (req.payload.kind == KIND_FINISH);
      cls.data_word = req.payload.data_word;
      cls.byte_count = (req.payload.byte_count > 4'd8) ? 4'd8 : req.payload.byte_count;
   end

   assign req.ready = (cnt_ff != QueueDepth[PtrW:0]) && !flush;
   assign push = req.valid && req.ready && (cls.finish || cls.byte_count != 4'd0);
   assign cmd_valid = (cnt_ff != '0);
   assign cmd = q_mem[rd_ptr_ff];

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_mem[wr_ptr_ff] <= cls;
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (cmd_take) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_ff + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, cmd_take};
      end
   end
endmodule
`default_nettype wire

FILE: sv/b2b_back.sv
// back part: packs bytes, runs compression with four G units, emits digest
`default_nettype none
module b2b_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            restart,
   input  b2b_pkg::csr_type     csr,
   input  b2b_pkg::cmd_type     cmd,
   input  wire logic            cmd_valid,
   output logic                 cmd_take,
   output logic                 busy,
   b2b_rsp_if.source            rsp
);
   import b2b_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PACK, S_COMP, S_FINAL, S_EMIT
   } state_type;

   state_type   state_ff;
   word_type    h_ff [ChainWords];
   word_type    m_ff [BlockWords];
   word_type    v_ff [16];
   logic [7:0]  fill_ff;
   word_type    cnt_lo_ff, cnt_hi_ff;
   logic [3:0]  round_ff;
   logic        half_ff;
   logic        fin_ff;
   logic [3:0]  left_ff;
   logic [3:0]  kpos_ff;
   word_type    word_ff;
   logic [2:0]  widx_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   word_type    g_a [4], g_b [4], g_c [4], g_d [4];
   word_type    o_a [4], o_b [4], o_c [4], o_d [4];
   logic [6:0]  dl;
   logic [3:0]  words;
   word_type    cnt_add;
   logic [64:0] cnt_sum;

   assign dl = eff_dl(csr.digest_length);
   assign words = 4'({1'b0, dl} + 8'd7 >> 3);
   assign cmd_take = (state_ff == S_IDLE) && cmd_valid && !restart;
   assign busy = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign cnt_add = fin_ff ? {56'd0, fill_ff} : 64'd128;
   assign cnt_sum = {1'b0, cnt_lo_ff} + {1'b0, cnt_add};

   // four G units on columns or diagonals
   always_comb begin
      logic [3:0] ia, ib, ic, id;
      word_type x, y, a, b, c, d;
      for (int i = 0; i < 4; i++) begin
         ia = 4'(i);
         ib = half_ff ? 4'(4 + ((i + 1) % 4)) : 4'(4 + i);
         ic = half_ff ? 4'(8 + ((i + 2) % 4)) : 4'(8 + i);
         id = half_ff ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
         x = m_ff[sigma(round_ff, {half_ff, 2'(i), 1'b0})];
         y = m_ff[sigma(round_ff, {half_ff, 2'(i), 1'b1})];
         a = v_ff[ia]; b = v_ff[ib]; c = v_ff[ic]; d = v_ff[id];
         a = a + b + x;
         d = d ^ a; d = {d[31:0], d[63:32]};
         c = c + d;
         b = b ^ c; b = {b[23:0], b[63:24]};
         a = a + b + y;
         d = d ^ a; d = {d[15:0], d[63:16]};
         c = c + d;
         b = b ^ c; b = {b[62:0], b[63]};
         g_a[i] = a; g_b[i] = b; g_c[i] = c; g_d[i] = d;
      end
      for (int i = 0; i < 4; i++) begin
         o_a[i] = g_a[i];
         o_b[half_ff ? (i + 1) % 4 : i] = g_b[i];
         o_c[half_ff ? (i + 2) % 4 : i] = g_c[i];
         o_d[half_ff ? (i + 3) % 4 : i] = g_d[i];
      end
   end

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff <= '0;
         cnt_lo_ff <= '0;
         cnt_hi_ff <= '0;
         for (int i = 0; i < ChainWords; i++)
            h_ff[i] <= (i == 0) ? iv_word(3'(i)) ^ param_word(csr) : iv_word(3'(i));
         for (int i = 0; i < BlockWords; i++) m_ff[i] <= '0;
      end else begin
         if (rsp.valid && rsp.ready && state_ff != S_EMIT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd_take) begin
                  word_ff <= cmd.data_word;
                  left_ff <= cmd.byte_count;
                  fin_ff <= cmd.finish;
                  state_ff <= cmd.finish ? S_COMP : S_PACK;
                  kpos_ff <= '0;
                  round_ff <= '0;
                  half_ff <= 1'b0;
               end
            end
            S_PACK: begin
               // one byte per cycle; full block compressed first
               if (fill_ff[7]) begin
                  state_ff <= S_COMP;
               end else begin
                  m_ff[fill_ff[6:3]] <= m_ff[fill_ff[6:3]] |
                     (word_type'(word_ff[7:0]) << {fill_ff[2:0], 3'b000});
                  word_ff <= word_ff >> 8;
                  fill_ff <= fill_ff + 8'd1;
                  left_ff <= left_ff - 4'd1;
                  if (left_ff == 4'd1) state_ff <= S_IDLE;
               end
               if (fill_ff[7]) begin
                  // set up working vector with updated counter
                  for (int i = 0; i < 8; i++) begin
                     v_ff[i] <= h_ff[i];
                     v_ff[i+8] <= iv_word(3'(i));
                  end
                  v_ff[12] <= iv_word(3'd4) ^ cnt_sum[63:0];
                  v_ff[13] <= iv_word(3'd5) ^ (cnt_hi_ff + 64'(cnt_sum[64]));
                  cnt_lo_ff <= cnt_sum[63:0];
                  cnt_hi_ff <= cnt_hi_ff + 64'(cnt_sum[64]);
                  round_ff <= '0;
                  half_ff <= 1'b0;
               end
            end
            S_COMP: begin
               if (fin_ff && round_ff == 4'd0 && !half_ff && kpos_ff == 4'd0) begin
                  // finish setup
                  for (int i = 0; i < 8; i++) begin
                     v_ff[i] <= h_ff[i];
                     v_ff[i+8] <= iv_word(3'(i));
                  end
                  v_ff[12] <= iv_word(3'd4) ^ cnt_sum[63:0];
                  v_ff[13] <= iv_word(3'd5) ^ (cnt_hi_ff + 64'(cnt_sum[64]));
                  v_ff[14] <= ~iv_word(3'd6);
                  v_ff[15] <= csr.last_node ? ~iv_word(3'd7) : iv_word(3'd7);
                  cnt_lo_ff <= cnt_sum[63:0];
                  cnt_hi_ff <= cnt_hi_ff + 64'(cnt_sum[64]);
                  kpos_ff <= 4'd1;
               end else begin
                  for (int i = 0; i < 4; i++) begin
                     v_ff[i] <= o_a[i];
                     v_ff[4+i] <= o_b[i];
                     v_ff[8+i] <= o_c[i];
                     v_ff[12+i] <= o_d[i];
                  end
                  half_ff <= ~half_ff;
                  if (half_ff) begin
                     round_ff <= round_ff + 4'd1;
                     if (round_ff == 4'(Rounds - 1)) state_ff <= S_FINAL;
                  end
               end
            end
            S_FINAL: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] ^ v_ff[i] ^ v_ff[i+8];
               for (int i = 0; i < BlockWords; i++) m_ff[i] <= '0;
               fill_ff <= '0;
               widx_ff <= '0;
               state_ff <= fin_ff ? S_EMIT : S_PACK;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.word_index <= widx_ff;
                  rsp_ff.last_word <= ({1'b0, widx_ff} + 4'd1 == words);
                  if ({1'b0, widx_ff} + 4'd1 == words && dl[2:0] != 3'd0)
                     rsp_ff.digest_word <= h_ff[widx_ff] &
                        ~(64'hFFFFFFFFFFFFFFFF << {dl[2:0], 3'b000});
                  else
                     rsp_ff.digest_word <= h_ff[widx_ff];
                  widx_ff <= widx_ff + 3'd1;
                  if ({1'b0, widx_ff} + 4'd1 == words) begin
                     state_ff <= S_IDLE;
                     fill_ff <= '0;
                     cnt_lo_ff <= '0;
                     cnt_hi_ff <= '0;
                     for (int i = 1; i < ChainWords; i++) h_ff[i] <= iv_word(3'(i));
                     h_ff[0] <= iv_word(3'd0) ^ param_word(csr);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: sv/blake2b_hash_engine_core.sv
// top level of the blake2b hash engine
//  channel | dir | payload                               | handshake
//  req     | in  | kind, data_word, byte_count           | req_valid / req_ready
//  rsp     | out | digest_word, word_index, last_word    | rsp_valid / rsp_ready
//  csr     | in  | csr_index, csr_data                   | csr_valid / csr_ready
// data items pack one byte a cycle, a full block being compressed first; a block
// compresses on four shared G units per half-round, between setup and fold.
// finish runs setup, rounds, fold, then one digest word per cycle if rsp_ready.
// reset is synchronous and gives the unkeyed 64-byte digest setup.
// a stalled rsp stalls the back part only; the front queue takes items until full.
`default_nettype none
module blake2b_hash_engine_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic [63:0]        req_data_word,
   input  wire logic [3:0]         req_byte_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [63:0]             rsp_digest_word,
   output logic [2:0]              rsp_word_index,
   output logic                    rsp_last_word,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [63:0]        csr_data
);
   import b2b_pkg::*;

   b2b_req_if req_ch ();
   b2b_rsp_if rsp_ch ();
   csr_type   csr_ff;
   cmd_type   cmd;
   logic      cmd_valid, cmd_take, busy, restart;

   assign req_ch.valid = req_valid;
   assign req_ch.payload = '{kind: req_kind, data_word: req_data_word,
                             byte_count: req_byte_count};
   assign req_ready = req_ch.ready;
   assign rsp_valid = rsp_ch.valid;
   assign rsp_ch.ready = rsp_ready;
   assign rsp_digest_word = rsp_ch.payload.digest_word;
   assign rsp_word_index = rsp_ch.payload.word_index;
   assign rsp_last_word = rsp_ch.payload.last_word;
   assign csr_ready = 1'b1;

   // register write takes effect next cycle and restarts the engine
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{digest_length: 7'd64, key_length: 7'd0, last_node: 1'b0};
         restart <= 1'b1;
      end else begin
         restart <= csr_valid &&
            (csr_index inside {CSR_DIGEST_LENGTH, CSR_KEY_LENGTH, CSR_LAST_NODE});
         if (csr_valid) begin
            case (csr_index)
               CSR_DIGEST_LENGTH: csr_ff.digest_length <= csr_data[6:0];
               CSR_KEY_LENGTH: csr_ff.key_length <= csr_data[6:0];
               CSR_LAST_NODE: csr_ff.last_node <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   b2b_front u_front (
      .clock, .reset, .flush(restart), .req(req_ch.sink),
      .cmd, .cmd_valid, .cmd_take
   );

   b2b_back u_back (
      .clock, .reset, .restart, .csr(csr_ff), .cmd, .cmd_valid, .cmd_take,
      .busy, .rsp(rsp_ch.source)
   );

   // a result only while the back part is busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result without busy back part");
   // queue never taken from while it is empty
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("take from empty queue");
   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset || restart)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word))
      else $error("result dropped");
endmodule
`default_nettype wire
